/* sv/srgb_to_cie_lightness_core_defines.svh */
// assertion macros for the srgb to cie lightness core checker
// expects clk and rst in the scope of use
`ifndef SRGB_TO_CIE_LIGHTNESS_CORE_DEFINES_SVH
`define SRGB_TO_CIE_LIGHTNESS_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define STLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define STLC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/stlc_pkg.sv */
// types, constants and elaboration-time functions for the srgb to cie lightness core
// no dependencies; used by stlc_cbrt and srgb_to_cie_lightness_core
package stlc_pkg;

  // unsigned q30 values, 1.0 = 2^30, one extra bit so that 1.0 fits
  localparam int QF = 30;
  localparam int QW = QF + 1;
  typedef logic [QW-1:0] q_t;

  localparam int LIN_ENTRIES = 256;

  // weighted luminance sum, scaled by 10000
  localparam int SUM_W = 44;
  typedef logic [SUM_W-1:0] sum_t;
  localparam sum_t W_R = sum_t'(2126);
  localparam sum_t W_G = sum_t'(7152);
  localparam sum_t W_B = sum_t'(722);
  localparam sum_t Y_ROUND = sum_t'(5000);

  // division of the sum by 10000: (sum >> 4) times ceil(2^49 / 625), top bits kept
  // the multiply is split into four 20 by 20 partial products
  localparam int DIV_M_W = 40;
  localparam int DIV_H = 20;
  localparam int DIV_SHIFT = 49;
  typedef logic [DIV_M_W-1:0] div_m_t;
  typedef logic [2*DIV_M_W-1:0] div_full_t;
  localparam logic [63:0] RECIP_625 = ((64'd1 << DIV_SHIFT) + 64'd624) / 64'd625;
  localparam div_m_t RECIP_H = div_m_t'(RECIP_625 >> DIV_H);
  localparam div_m_t RECIP_L = div_m_t'(RECIP_625 & ((64'd1 << DIV_H) - 64'd1));
  localparam int DIV_STAGES = 2;

  // y above this takes the cube root branch
  localparam q_t Y_KNEE = q_t'((64'd8856 << QF) / 64'd1000000);

  // linear segment: floor(((903292*y) >> (30-fb) + 500) / 1000)
  localparam int LO_Y_W = 24;
  localparam int LO_PROD_W = 44;
  typedef logic [LO_PROD_W-1:0] lo_prod_t;
  localparam lo_prod_t LO_GAIN = lo_prod_t'(903292);
  localparam int LO_X_W = 26;
  typedef logic [LO_X_W-1:0] lo_x_t;
  localparam lo_x_t LO_ROUND = lo_x_t'(500);
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W = 27;
  localparam int RECIP_PROD_W = LO_X_W + RECIP_W;
  typedef logic [RECIP_PROD_W-1:0] recip_prod_t;
  localparam recip_prod_t RECIP_1000 =
    recip_prod_t'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);

  // cube root segment: 116*f - 16
  localparam int SC_W = 38;
  typedef logic [SC_W-1:0] sc_t;
  localparam sc_t HI_GAIN = sc_t'(116);
  localparam sc_t HI_BIAS = sc_t'(64'd16 << QF);

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> QF;
  endfunction

  function automatic logic [63:0] q_pow5(logic [63:0] y);
    logic [63:0] s;
    logic [63:0] q;
    s = q_mul(y, y);
    q = q_mul(s, s);
    return q_mul(q, y);
  endfunction

  // largest y in [0,1] with q_pow5(y) <= a
  function automatic logic [63:0] q_root5(logic [63:0] a);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << QF;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (q_pow5(mid) <= a) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // srgb decoding of one 8-bit code to linear light
  function automatic q_t lin_value(int unsigned c);
    logic [63:0] cc;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    cc = 64'(c) & 64'hFF;
    if (cc <= 64'd10) begin
      r = (((cc * 64'd100) << QF) + 64'd164730) / 64'd329460;
    end else begin
      t = (((64'd1000 * cc + 64'd14025) << QF) + 64'd134512) / 64'd269025;
      t2 = q_mul(t, t);
      r = q_mul(t2, q_root5(t2));
    end
    return q_t'(r);
  endfunction

endpackage

/* sv/stlc_cbrt.sv */
// pipelined q30 cube root: one result bit per two register stages
// depends on stlc_pkg
module stlc_cbrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  stlc_pkg::q_t  in_y,
  output logic          out_valid,
  output stlc_pkg::q_t  out_y,
  output stlc_pkg::q_t  out_f
);

  localparam int NB = stlc_pkg::QW;
  localparam int QF = stlc_pkg::QF;
  localparam int PW = 2 * NB;

  logic         s_v    [NB];
  stlc_pkg::q_t s_y    [NB];
  stlc_pkg::q_t s_f    [NB];
  logic         m_v    [NB];
  stlc_pkg::q_t m_y    [NB];
  stlc_pkg::q_t m_f    [NB];
  stlc_pkg::q_t m_cand [NB];
  stlc_pkg::q_t m_sq   [NB];

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int B = NB - 1 - j;

    logic         cur_v;
    stlc_pkg::q_t cur_y;
    stlc_pkg::q_t cur_f;
    stlc_pkg::q_t cand_c;
    logic [PW-1:0] sq_full;
    logic [PW-1:0] cube_full;
    logic          keep;

    if (j == 0) begin : g_first
      assign cur_v = in_valid;
      assign cur_y = in_y;
      assign cur_f = '0;
    end else begin : g_rest
      assign cur_v = s_v[j-1];
      assign cur_y = s_y[j-1];
      assign cur_f = s_f[j-1];
    end

    // trial value with this bit set, then its square
    assign cand_c  = cur_f | (stlc_pkg::q_t'(1) << B);
    assign sq_full = PW'(cand_c) * PW'(cand_c);

    // cube of the trial, kept if it stays at or below y and f is not already 1.0
    assign cube_full = PW'(m_sq[j]) * PW'(m_cand[j]);
    assign keep = (cube_full[QF+NB-1:QF] <= m_y[j]) && !m_f[j][NB-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        m_v[j] <= 1'b0;
        s_v[j] <= 1'b0;
      end else if (adv) begin
        m_v[j] <= cur_v;
        s_v[j] <= m_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_y[j]    <= cur_y;
        m_f[j]    <= cur_f;
        m_cand[j] <= cand_c;
        m_sq[j]   <= sq_full[QF+NB-1:QF];
        s_y[j]    <= m_y[j];
        s_f[j]    <= keep ? m_cand[j] : m_f[j];
      end
    end
  end

  assign out_valid = s_v[NB-1];
  assign out_y     = s_y[NB-1];
  assign out_f     = s_f[NB-1];

endmodule

/* sv/srgb_to_cie_lightness_core.sv */
// srgb pixel to cie l* lightness, fully pipelined, one pixel per clock while the output buffer is not full
// depends on stlc_pkg and stlc_cbrt
//
// Each accepted pixel gives one lightness value, unsigned with FRAC_BITS
// fraction bits (white gives 100 << FRAC_BITS). A new pixel can be taken in
// every clock cycle while the output buffer is not full. Each pixel passes
// through registered steps in order: the gamma lookup, the weighted sum, the
// division by 10000 (a reciprocal multiply cut into partial products), the
// cube root (one result bit every two stages, each stage holding one
// multiplier) and scaling and rounding. Results wait in a two-entry output
// buffer; the pipeline holds still only while that buffer is full, so
// pixel_ready never depends on result_ready in the same cycle.
module srgb_to_cie_lightness_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [FRAC_BITS+6:0] lightness
);

  localparam int OUT_W = FRAC_BITS + 7;
  localparam int DROP  = stlc_pkg::QF - FRAC_BITS;
  localparam int NS    = stlc_pkg::DIV_STAGES;
  localparam int MW    = stlc_pkg::DIV_M_W;
  localparam int H     = stlc_pkg::DIV_H;
  localparam logic [1:0] OB_FULL = 2'd2;

  logic adv;

  // gamma lookup
  stlc_pkg::q_t lin_lut [stlc_pkg::LIN_ENTRIES];
  for (genvar i = 0; i < stlc_pkg::LIN_ENTRIES; i++) begin : g_lut
    localparam stlc_pkg::q_t V = stlc_pkg::lin_value(i);
    assign lin_lut[i] = V;
  end

  logic         v_lin;
  stlc_pkg::q_t lin_r;
  stlc_pkg::q_t lin_g;
  stlc_pkg::q_t lin_b;

  logic           v_prod;
  stlc_pkg::sum_t prod_r;
  stlc_pkg::sum_t prod_g;
  stlc_pkg::sum_t prod_b;
  stlc_pkg::sum_t sum_c;

  logic                div_v [NS+1];
  stlc_pkg::div_m_t    div_m;
  stlc_pkg::div_m_t    pp_hh;
  stlc_pkg::div_m_t    pp_hl;
  stlc_pkg::div_m_t    pp_lh;
  stlc_pkg::div_m_t    pp_ll;
  stlc_pkg::div_full_t div_full_c;
  stlc_pkg::q_t        div_y;

  logic         cb_v;
  stlc_pkg::q_t cb_y;
  stlc_pkg::q_t cb_f;

  logic               v_p1;
  logic               p1_hi;
  stlc_pkg::lo_prod_t p1_lo;
  stlc_pkg::sc_t      p1_sc;

  logic             v_p2;
  logic             p2_hi;
  logic [OUT_W-1:0] p2_hres;
  stlc_pkg::lo_x_t  p2_x;
  logic [OUT_W-1:0] hres_c;
  stlc_pkg::sc_t    hdiff_c;
  stlc_pkg::lo_x_t  x_c;

  logic                  v_p3;
  logic                  p3_hi;
  logic [OUT_W-1:0]      p3_hres;
  stlc_pkg::recip_prod_t p3_m;
  logic [OUT_W-1:0]      res_c;

  logic             ob_wr;
  logic             ob_rd;
  logic [1:0]       ob_count;
  logic [1:0]       ob_count_next;
  logic [OUT_W-1:0] ob_data [2];
  logic             push;
  logic             pop;

  assign adv         = (ob_count != OB_FULL);
  assign pixel_ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r  <= lin_lut[red];
      lin_g  <= lin_lut[green];
      lin_b  <= lin_lut[blue];
      prod_r <= stlc_pkg::sum_t'(lin_r) * stlc_pkg::W_R;
      prod_g <= stlc_pkg::sum_t'(lin_g) * stlc_pkg::W_G;
      prod_b <= stlc_pkg::sum_t'(lin_b) * stlc_pkg::W_B;
    end
  end

  assign sum_c = prod_r + prod_g + prod_b + stlc_pkg::Y_ROUND;

  // quotient is the top bits of (sum >> 4) times the reciprocal of 625
  assign div_full_c = {pp_hh, pp_ll}
                    + (stlc_pkg::div_full_t'(pp_hl) << H)
                    + (stlc_pkg::div_full_t'(pp_lh) << H);

  always_ff @(posedge clk) begin
    if (adv) begin
      div_m <= sum_c[stlc_pkg::SUM_W-1:stlc_pkg::SUM_W-MW];
      pp_hh <= stlc_pkg::div_m_t'(div_m[MW-1:H]) * stlc_pkg::RECIP_H;
      pp_hl <= stlc_pkg::div_m_t'(div_m[MW-1:H]) * stlc_pkg::RECIP_L;
      pp_lh <= stlc_pkg::div_m_t'(div_m[H-1:0]) * stlc_pkg::RECIP_H;
      pp_ll <= stlc_pkg::div_m_t'(div_m[H-1:0]) * stlc_pkg::RECIP_L;
      div_y <= div_full_c[2*MW-1:stlc_pkg::DIV_SHIFT];
    end
  end

  stlc_cbrt u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_v[NS]),
    .in_y      (div_y),
    .out_valid (cb_v),
    .out_y     (cb_y),
    .out_f     (cb_f)
  );

  // both segments are worked out, the knee compare picks one at the end
  always_comb begin
    hdiff_c = p1_sc - stlc_pkg::HI_BIAS + (stlc_pkg::sc_t'(1) << (DROP - 1));
    if (p1_sc <= stlc_pkg::HI_BIAS) begin
      hres_c = '0;
    end else begin
      hres_c = OUT_W'(hdiff_c >> DROP);
    end
  end

  assign x_c   = stlc_pkg::lo_x_t'(p1_lo >> DROP) + stlc_pkg::LO_ROUND;
  assign res_c = p3_hi ? p3_hres : OUT_W'(p3_m >> stlc_pkg::RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_hi   <= cb_y > stlc_pkg::Y_KNEE;
      p1_lo   <= stlc_pkg::lo_prod_t'(cb_y[stlc_pkg::LO_Y_W-1:0]) * stlc_pkg::LO_GAIN;
      p1_sc   <= stlc_pkg::sc_t'(cb_f) * stlc_pkg::HI_GAIN;
      p2_hi   <= p1_hi;
      p2_hres <= hres_c;
      p2_x    <= x_c;
      p3_hi   <= p2_hi;
      p3_hres <= p2_hres;
      p3_m    <= stlc_pkg::recip_prod_t'(p2_x) * stlc_pkg::RECIP_1000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_lin  <= 1'b0;
      v_prod <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        div_v[k] <= 1'b0;
      end
      v_p1 <= 1'b0;
      v_p2 <= 1'b0;
      v_p3 <= 1'b0;
    end else if (adv) begin
      v_lin    <= pixel_valid;
      v_prod   <= v_lin;
      div_v[0] <= v_prod;
      for (int k = 0; k < NS; k++) begin
        div_v[k+1] <= div_v[k];
      end
      v_p1 <= cb_v;
      v_p2 <= v_p1;
      v_p3 <= v_p2;
    end
  end

  // output buffer
  assign push = adv && v_p3;
  assign pop  = result_valid && result_ready;

  always_comb begin
    ob_count_next = ob_count;
    if (push && !pop) begin
      ob_count_next = ob_count + 2'd1;
    end else if (pop && !push) begin
      ob_count_next = ob_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_data[ob_wr] <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_count <= '0;
    end else begin
      if (push) begin
        ob_wr <= ~ob_wr;
      end
      if (pop) begin
        ob_rd <= ~ob_rd;
      end
      ob_count <= ob_count_next;
    end
  end

  assign result_valid = (ob_count != 2'd0);
  assign lightness    = ob_data[ob_rd];

endmodule

/* sv/stlc_checker.sv */
// port-level checks for srgb_to_cie_lightness_core, bound to the top level
// depends on srgb_to_cie_lightness_core_defines.svh
`include "srgb_to_cie_lightness_core_defines.svh"

module stlc_checker #(
  parameter int FRAC_BITS = 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_valid,
  input logic                 pixel_ready,
  input logic [7:0]           red,
  input logic [7:0]           green,
  input logic [7:0]           blue,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [FRAC_BITS+6:0] lightness
);

  localparam int OUT_W = FRAC_BITS + 7;
  localparam logic [OUT_W-1:0] L_MAX = OUT_W'(100) << FRAC_BITS;

  logic [7:0]  outstanding;
  logic        in_acc;
  logic        out_acc;
  logic        in_wait;
  logic        out_wait;
  logic [23:0] pixel;

  assign in_acc   = pixel_valid && pixel_ready;
  assign out_acc  = result_valid && result_ready;
  assign in_wait  = pixel_valid && !pixel_ready;
  assign out_wait = result_valid && !result_ready;
  assign pixel    = {red, green, blue};

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_acc) - 8'(out_acc);
    end
  end

  `STLC_ASSERT_IMP(a_range, result_valid, lightness <= L_MAX, "lightness above 100")
  `STLC_ASSERT_IMP(a_no_spurious, result_valid, outstanding != 8'd0, "result without a pixel")
  `STLC_ASSERT_IMP(a_ready_when_empty, !result_valid, pixel_ready, "input stalled with empty output")
  `STLC_ASSERT_NXT(a_hold, out_wait, result_valid && $stable(lightness), "result not held")
  `STLC_ASSERT_NXT(a_pixel_hold, in_wait, pixel_valid && $stable(pixel), "pixel not held")

endmodule

bind srgb_to_cie_lightness_core stlc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_stlc_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .lightness    (lightness)
);
